// File: rtl/igsd_pkg.sv
// ----------------------------------------------------------------------------
// IF gain stage distributor package
// Stage ranges, widths and command word layout shared by the distributor.
// ----------------------------------------------------------------------------
package igsd_pkg;

  localparam int StageCount = 6;
  localparam int StageIdxW  = 3;
  localparam int TargetW    = 11;
  localparam int GainW      = 9;
  localparam int CalcW      = 13;
  localparam int CmdW       = 32;
  localparam int CmdGainW   = 16;

  typedef logic signed [GainW-1:0] gain_t;
  typedef logic signed [CalcW-1:0] calc_t;

  // Per-stage tables in tenths of dB, stage 1 at index 0.
  localparam gain_t StageMin [StageCount] = '{-9'sd30, 9'sd0, 9'sd0, 9'sd0, 9'sd30, 9'sd30};
  localparam gain_t StageMax [StageCount] = '{9'sd60, 9'sd90, 9'sd90, 9'sd20, 9'sd150, 9'sd150};
  localparam gain_t StageStep[StageCount] = '{9'sd90, 9'sd30, 9'sd30, 9'sd10, 9'sd30, 9'sd30};

  // Sum of all stage minimums.
  localparam calc_t MinSum = 13'sd30;

endpackage

// File: rtl/if_gain_stage_distributor_top.sv
// ----------------------------------------------------------------------------
// IF gain stage distributor
// Greedy split of a requested IF gain over six tuner IF gain stages.
// ----------------------------------------------------------------------------
// A transaction runs a setup step and a candidate search for each stage,
// stage 6 first, in the shared error unit, then emits its six results on
// consecutive cycles. The single add, abs and compare unit evaluates one
// candidate per cycle, and a new transaction is accepted only once the last
// result has been issued. Results cannot be stalled. Reset clears the
// sequencer and the tuner_is_supported register.
module if_gain_stage_distributor_top (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [igsd_pkg::TargetW-1:0]    in_target_gain_tenths,
  output logic                                   out_strobe,
  output logic [igsd_pkg::StageIdxW-1:0]         out_stage_number,
  output logic signed [igsd_pkg::GainW-1:0]      out_stage_gain_tenths,
  output logic [igsd_pkg::CmdW-1:0]              out_command_word,
  output logic                                   out_last_stage,
  input  logic                                   cfg_wr_en,
  input  logic                                   cfg_wr_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SEARCH,
    ST_EMIT
  } state_t;

  localparam logic [igsd_pkg::StageIdxW-1:0] LastIdx =
    igsd_pkg::StageIdxW'(igsd_pkg::StageCount - 1);

  state_t                               state_r;
  logic                                 tuner_is_supported_r;
  logic [igsd_pkg::StageIdxW-1:0]       idx_r;
  igsd_pkg::gain_t                      chosen_r [igsd_pkg::StageCount];
  igsd_pkg::calc_t                      target_r;
  igsd_pkg::calc_t                      sum_r;
  igsd_pkg::calc_t                      others_r;
  igsd_pkg::calc_t                      best_r;
  igsd_pkg::gain_t                      cand_r;

  logic                                 out_strobe_r;
  logic [igsd_pkg::StageIdxW-1:0]       out_stage_number_r;
  igsd_pkg::gain_t                      out_stage_gain_r;
  logic [igsd_pkg::CmdW-1:0]            out_command_word_r;
  logic                                 out_last_stage_r;

  // Shared error unit: one candidate per cycle.
  igsd_pkg::gain_t                      cur_chosen;
  igsd_pkg::calc_t                      cand_sum;
  igsd_pkg::calc_t                      diff;
  igsd_pkg::calc_t                      err;
  logic                                 take;
  igsd_pkg::gain_t                      new_choice;
  logic                                 cand_last;
  logic [igsd_pkg::StageIdxW-1:0]       stage_num;

  assign cur_chosen = chosen_r[idx_r];
  assign cand_sum   = others_r + igsd_pkg::CalcW'(cand_r);
  assign diff       = target_r - cand_sum;
  assign err        = diff[igsd_pkg::CalcW-1] ? -diff : diff;
  assign take       = (err < best_r);
  assign new_choice = take ? cand_r : cur_chosen;
  assign cand_last  = (cand_r == igsd_pkg::StageMax[idx_r]);
  assign stage_num  = idx_r + igsd_pkg::StageIdxW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r              <= ST_IDLE;
      tuner_is_supported_r <= 1'b0;
      out_strobe_r         <= 1'b0;
      idx_r                <= '0;
    end else begin
      out_strobe_r <= 1'b0;
      if (cfg_wr_en) begin
        tuner_is_supported_r <= cfg_wr_data;
      end
      case (state_r)
        ST_IDLE: begin
          // An unsupported tuner still accepts the transaction but stays idle.
          if (start && tuner_is_supported_r) begin
            target_r <= igsd_pkg::CalcW'(in_target_gain_tenths);
            sum_r    <= igsd_pkg::MinSum;
            for (int i = 0; i < igsd_pkg::StageCount; i++) begin
              chosen_r[i] <= igsd_pkg::StageMin[i];
            end
            idx_r    <= LastIdx;
            state_r  <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          // The error bound restarts at the target for every stage.
          others_r <= sum_r - igsd_pkg::CalcW'(cur_chosen);
          best_r   <= target_r;
          cand_r   <= igsd_pkg::StageMin[idx_r];
          state_r  <= ST_SEARCH;
        end
        ST_SEARCH: begin
          if (take) begin
            best_r          <= err;
            chosen_r[idx_r] <= cand_r;
          end
          if (cand_last) begin
            sum_r <= others_r + igsd_pkg::CalcW'(new_choice);
            if (idx_r == '0) begin
              state_r <= ST_EMIT;
            end else begin
              idx_r   <= idx_r - igsd_pkg::StageIdxW'(1);
              state_r <= ST_SETUP;
            end
          end else begin
            cand_r <= cand_r + igsd_pkg::StageStep[idx_r];
          end
        end
        ST_EMIT: begin
          // Stage 1 first; idx_r now walks upward.
          out_strobe_r       <= 1'b1;
          out_stage_number_r <= stage_num;
          out_stage_gain_r   <= cur_chosen;
          out_command_word_r <= {{(igsd_pkg::CmdW - igsd_pkg::CmdGainW
                                   - igsd_pkg::StageIdxW){1'b0}},
                                 stage_num,
                                 igsd_pkg::CmdGainW'(cur_chosen)};
          out_last_stage_r   <= (idx_r == LastIdx);
          if (idx_r == LastIdx) begin
            state_r <= ST_IDLE;
          end else begin
            idx_r <= stage_num;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy                  = (state_r != ST_IDLE);
  assign out_strobe            = out_strobe_r;
  assign out_stage_number      = out_stage_number_r;
  assign out_stage_gain_tenths = out_stage_gain_r;
  assign out_command_word      = out_command_word_r;
  assign out_last_stage        = out_last_stage_r;

endmodule

// File: bench/tb_if_gain_stage_distributor_top.sv
// ----------------------------------------------------------------------------
// IF gain stage distributor testbench
// Drives target gains into the distributor, predicts the greedy six-stage
// split for every accepted transaction and checks each stage result in order.
// ----------------------------------------------------------------------------
module tb_if_gain_stage_distributor_top;

  // Stage tables in tenths of dB, stage 1 at index 0. These are kept here
  // on purpose so the split is predicted independently of the design.
  localparam int GainLo   [6] = '{-30, 0, 0, 0, 30, 30};
  localparam int GainHi   [6] = '{60, 90, 90, 20, 150, 150};
  localparam int GainStep [6] = '{90, 30, 30, 10, 30, 30};

  // A pause long enough to cover any work still in flight when nothing more
  // is expected (the unsupported tuner case).
  localparam int SettlePause = 48;
  localparam int CycleLimit  = 200000;

  // One gain per stage, stage 1 in element 0.
  typedef logic [5:0][igsd_pkg::GainW-1:0] gain_set_t;

  // Every stage at its minimum, and every stage at its maximum.
  localparam gain_set_t AllMin = {9'd30, 9'd30, 9'd0, 9'd0, 9'd0, -9'sd30};
  localparam gain_set_t AllMax = {9'd150, 9'd150, 9'd20, 9'd90, 9'd90, 9'd60};

  typedef struct packed {
    logic [igsd_pkg::StageIdxW-1:0]    stage_number;
    logic signed [igsd_pkg::GainW-1:0] stage_gain_tenths;
    logic [igsd_pkg::CmdW-1:0]         command_word;
    logic                              last_stage;
  } stage_setting_t;

  typedef struct packed {
    logic signed [igsd_pkg::TargetW-1:0] target;
    bit                                  typed;
    gain_set_t                           gains;
  } target_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  logic signed [igsd_pkg::TargetW-1:0] in_target_gain_tenths;
  logic                                out_strobe;
  logic [igsd_pkg::StageIdxW-1:0]      out_stage_number;
  logic signed [igsd_pkg::GainW-1:0]   out_stage_gain_tenths;
  logic [igsd_pkg::CmdW-1:0]           out_command_word;
  logic                                out_last_stage;
  logic                                cfg_wr_en;
  logic                                cfg_wr_data;

  // Stage settings still owed by the block, oldest first.
  stage_setting_t stage_settings_due [$];

  // Our copy of the tuner_is_supported register.
  bit tuner_on;

  int fail_count;
  int targets_accepted;
  int results_checked;
  int cycle_count;

  if_gain_stage_distributor_top DUT (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_target_gain_tenths (in_target_gain_tenths),
    .out_strobe            (out_strobe),
    .out_stage_number      (out_stage_number),
    .out_stage_gain_tenths (out_stage_gain_tenths),
    .out_command_word      (out_command_word),
    .out_last_stage        (out_last_stage),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_wr_data           (cfg_wr_data)
  );

  // Period of 12 time units.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Greedy split of a target gain. Every stage starts at its minimum; from
  // stage 6 down to stage 1 each stage sweeps its values in ascending order
  // and keeps one only when it strictly improves on the running error. That
  // error restarts at the signed target for each stage, so a negative or zero
  // target can never be improved upon and every stage stays at its minimum.
  // Ties keep the lower value because the comparison is strict.
  function automatic gain_set_t predict_split(input logic signed [igsd_pkg::TargetW-1:0] target);
    gain_set_t pick;
    int        others;
    int        best;
    int        err;
    for (int s = 0; s < 6; s++) begin
      pick[s] = GainLo[s][igsd_pkg::GainW-1:0];
    end
    for (int s = 5; s >= 0; s--) begin
      best   = target;
      others = 0;
      for (int j = 0; j < 6; j++) begin
        if (j != s) begin
          others += $signed(pick[j]);
        end
      end
      for (int g = GainLo[s]; g <= GainHi[s]; g += GainStep[s]) begin
        err = target - (others + g);
        if (err < 0) begin
          err = -err;
        end
        if (err < best) begin
          best    = err;
          pick[s] = g[igsd_pkg::GainW-1:0];
        end
      end
    end
    return pick;
  endfunction

  // Turns one gain set into the six stage results, in stage order. The
  // command word carries the stage number above the 16-bit sign-extended gain.
  function automatic void queue_stage_settings(input gain_set_t gains);
    stage_setting_t item;
    for (int s = 0; s < 6; s++) begin
      item.stage_number      = igsd_pkg::StageIdxW'(s + 1);
      item.stage_gain_tenths = gains[s];
      item.command_word      = {13'd0, item.stage_number, {7{gains[s][8]}}, gains[s]};
      item.last_stage        = (s == 5);
      stage_settings_due     = {stage_settings_due, item};
    end
  endfunction

  // Most targets land where the stages can actually reach; some sit exactly
  // halfway between steps to provoke ties, and the rest span all 11 bits.
  function automatic logic signed [igsd_pkg::TargetW-1:0] draw_target();
    int pick;
    int v;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      v = int'($urandom_range(0, 680)) - 40;
    end else if (pick < 8) begin
      v = int'($urandom_range(0, 64)) * 10 + 5;
    end else begin
      v = $urandom;
    end
    return v[igsd_pkg::TargetW-1:0];
  endfunction

  // Directed targets. Rows marked typed carry results that follow directly
  // from the stage tables; the others go through the predictor.
  function automatic target_row_t directed_row(input int i);
    target_row_t row;
    row.typed = 1'b0;
    row.gains = '0;
    case (i)
      0:  begin row.target = -11'sd1024; row.typed = 1'b1; row.gains = AllMin; end
      1:  begin row.target = -11'sd1;    row.typed = 1'b1; row.gains = AllMin; end
      2:  begin row.target = 11'sd0;     row.typed = 1'b1; row.gains = AllMin; end
      3:  begin row.target = 11'sd1023;  row.typed = 1'b1; row.gains = AllMax; end
      4:  row.target = -11'sd30;
      5:  row.target = 11'sd5;
      6:  row.target = 11'sd15;
      7:  row.target = 11'sd29;
      8:  row.target = 11'sd30;
      9:  row.target = 11'sd31;
      10: row.target = 11'sd45;
      11: row.target = 11'sd75;
      12: row.target = 11'sd100;
      13: row.target = 11'sd105;
      14: row.target = 11'sd165;
      15: row.target = 11'sd195;
      16: row.target = 11'sd255;
      17: row.target = 11'sd300;
      18: row.target = 11'sd333;
      19: row.target = 11'sd359;
      20: row.target = 11'sd405;
      21: row.target = 11'sd511;
      22: row.target = 11'sd560;
      23: row.target = 11'sd600;
      default: row.target = 11'sd700;
    endcase
    return row;
  endfunction

  // Presents one target and waits for the block to take it. Idle bursts of
  // random length are inserted at random; sometimes the burst is held until
  // busy drops so that the gap also lands right where the block would accept.
  // Expectations are recorded at the accepting edge, and only while the tuner
  // is marked supported.
  task automatic send_target(input logic signed [igsd_pkg::TargetW-1:0] target,
                             input gain_set_t expected, input bit with_idle);
    int idle_len;
    idle_len = 0;
    if (with_idle && $urandom_range(0, 2) == 0) begin
      idle_len = $urandom_range(1, 4);
    end
    if (idle_len > 0) begin
      @(negedge clk);
      start <= 1'b0;
      if ($urandom_range(0, 1) == 1) begin
        while (busy) @(negedge clk);
      end
      repeat (idle_len - 1) @(negedge clk);
    end
    @(negedge clk);
    start                 <= 1'b1;
    in_target_gain_tenths <= target;
    @(posedge clk);
    while (busy) @(posedge clk);
    targets_accepted++;
    if (tuner_on) begin
      queue_stage_settings(expected);
    end
  endtask

  // Lowers start, waits for every owed result, then lets the block finish
  // any transaction that produces nothing.
  task automatic settle_outputs();
    @(negedge clk);
    start <= 1'b0;
    while (stage_settings_due.size() != 0) @(posedge clk);
    repeat (SettlePause) @(posedge clk);
  endtask

  // Register writes only happen with the block idle.
  task automatic set_tuner_supported(input bit on);
    settle_outputs();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= on;
    @(posedge clk);
    tuner_on = on;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Result checker. The result ports are sampled at the rising edge that
  // ends the strobe cycle, and each result is matched against the oldest
  // owed stage setting.
  always @(posedge clk) begin : check_results
    stage_setting_t want;
    if (rst_n && out_strobe === 1'b1) begin
      if (stage_settings_due.size() == 0) begin
        $error("Result for stage %0d arrived with nothing expected", out_stage_number);
        fail_count++;
      end else begin
        want = stage_settings_due.pop_front();
        results_checked++;
        if (out_stage_number !== want.stage_number) begin
          $error("stage_number: expected %0d, actual %0d", want.stage_number, out_stage_number);
          fail_count++;
        end
        if (out_stage_gain_tenths !== want.stage_gain_tenths) begin
          $error("stage_gain_tenths: expected %0d, actual %0d",
                 $signed(want.stage_gain_tenths), $signed(out_stage_gain_tenths));
          fail_count++;
        end
        if (out_command_word !== want.command_word) begin
          $error("command_word: expected %h, actual %h", want.command_word, out_command_word);
          fail_count++;
        end
        if (out_last_stage !== want.last_stage) begin
          $error("last_stage: expected %0d, actual %0d", want.last_stage, out_last_stage);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: a hung handshake or a block that never finishes ends here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results still owed",
               cycle_count, stage_settings_due.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    target_row_t                         row;
    logic signed [igsd_pkg::TargetW-1:0] t;
    start                 = 1'b0;
    in_target_gain_tenths = '0;
    cfg_wr_en             = 1'b0;
    cfg_wr_data           = 1'b0;
    tuner_on              = 1'b0;
    fail_count            = 0;
    targets_accepted      = 0;
    results_checked       = 0;
    cycle_count           = 0;
    rst_n                 = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Straight out of reset the tuner is unsupported, so these transactions
    // must be accepted without producing a single result.
    send_target(11'sd0, AllMin, 1'b0);
    send_target(11'sd300, AllMin, 1'b1);
    send_target(-11'sd1024, AllMin, 1'b0);

    // Directed part: extremes of the target, negative and zero targets that
    // leave every stage at its minimum, exact tie points and reachable sums.
    set_tuner_supported(1'b1);
    for (int i = 0; i < 25; i++) begin
      row = directed_row(i);
      send_target(row.target, row.typed ? row.gains : predict_split(row.target), 1'b1);
    end

    // Random targets with idle bursts on the input side.
    for (int n = 0; n < 125; n++) begin
      t = draw_target();
      send_target(t, predict_split(t), 1'b1);
    end

    // Turn support off again; everything sent now must be silently dropped.
    set_tuner_supported(1'b0);
    for (int n = 0; n < 20; n++) begin
      t = draw_target();
      send_target(t, predict_split(t), 1'b1);
    end

    // Final stretch back at full support, back to back with no idling.
    set_tuner_supported(1'b1);
    for (int n = 0; n < 60; n++) begin
      t = draw_target();
      send_target(t, predict_split(t), 1'b0);
    end

    settle_outputs();
    $display("Accepted %0d target transactions and checked %0d stage results,",
             targets_accepted, results_checked);
    $display("with the tuner supported, unsupported from reset and switched off again.");
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: if_gain_stage_distributor_top.f
rtl/igsd_pkg.sv
rtl/if_gain_stage_distributor_top.sv
bench/tb_if_gain_stage_distributor_top.sv
